>>> src/sm4_pkg.sv
// Shared constants and helper functions for the SM4 cipher unit.
`timescale 1ns / 1ps

package sm4_pkg;

    localparam int ROUND_COUNT = 32;
    localparam int RK_AW       = $clog2(ROUND_COUNT);

    // Configuration register indexes
    localparam logic [1:0] CFG_KEY_HIGH = 2'd0;
    localparam logic [1:0] CFG_KEY_LOW  = 2'd1;
    localparam logic [1:0] CFG_DECRYPT  = 2'd2;

    // Key schedule system parameters
    localparam logic [31:0] FK0 = 32'hA3B1BAC6;
    localparam logic [31:0] FK1 = 32'h56AA3350;
    localparam logic [31:0] FK2 = 32'h677D9197;
    localparam logic [31:0] FK3 = 32'hB27022DC;

    localparam logic [7:0] SBOX [256] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    // Four parallel S-box lookups (the tau transform)
    function automatic logic [31:0] tau(input logic [31:0] v);
        return {SBOX[v[31:24]], SBOX[v[23:16]], SBOX[v[15:8]], SBOX[v[7:0]]};
    endfunction

    // CK word: byte b (MSB first) is (4i+b)*7 mod 256
    function automatic logic [31:0] ck_word(input logic [RK_AW-1:0] i);
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        b0 = 8'({i, 2'd0} * 8'd7);
        b1 = 8'({i, 2'd1} * 8'd7);
        b2 = 8'({i, 2'd2} * 8'd7);
        b3 = 8'({i, 2'd3} * 8'd7);
        return {b0, b1, b2, b3};
    endfunction

endpackage

>>> src/sm4_round.sv
// One SM4 round: tau substitution and linear mix, for data rounds or key schedule.
`timescale 1ns / 1ps

module sm4_round import sm4_pkg::*; (
    input  logic [31:0] i_x0,
    input  logic [31:0] i_x1,
    input  logic [31:0] i_x2,
    input  logic [31:0] i_x3,
    input  logic [31:0] i_rk,      // round key, or CK word in key schedule
    input  logic        i_key_mix, // 1: key schedule linear transform L'
    output logic [31:0] o_nx
);

    logic [31:0] t;
    logic [31:0] mix_data;
    logic [31:0] mix_key;

    // Nonlinear part
    assign t = tau(i_x1 ^ i_x2 ^ i_x3 ^ i_rk);

    // Linear transforms L and L'
    assign mix_data = t ^ {t[29:0], t[31:30]} ^ {t[21:0], t[31:22]}
                    ^ {t[13:0], t[31:14]} ^ {t[7:0], t[31:8]};
    assign mix_key  = t ^ {t[18:0], t[31:19]} ^ {t[8:0], t[31:9]};

    assign o_nx = i_x0 ^ (i_key_mix ? mix_key : mix_data);

endmodule

>>> src/sm4_block_cipher_unit.sv
// Top level of the SM4 block cipher unit: control, round-key RAM and I/O beats.
`timescale 1ns / 1ps

// SM4 with a 128-bit key, one 128-bit block per input beat. From accept to
// result a block passes a load step that prefetches the first round key, 32
// rounds at one round per clock, and a done step that hands the result to the
// output register once that register is free. The round keys live in a
// 32 x 32 RAM with a registered read; the next round key is read while the
// current round computes. After reset or a key register write the first block
// first runs the key schedule, writing one round key per clock. Decrypt mode
// reads the RAM in reverse order and does not require a new schedule. Input is
// taken only while the core is idle; a finished result waits in the output
// register while the next block is accepted. Configuration writes are always
// ready and must only be made while no block is in flight.
module sm4_block_cipher_unit import sm4_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write channel
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    // input blocks
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [127:0] s_axis_tdata,  // [63:0] block_high, [127:64] block_low
    // result blocks
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [127:0] m_axis_tdata   // [63:0] result_high, [127:64] result_low
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_EXPAND = 3'd1;
    localparam logic [2:0] ST_LOAD   = 3'd2;
    localparam logic [2:0] ST_CRYPT  = 3'd3;
    localparam logic [2:0] ST_DONE   = 3'd4;

    localparam logic [RK_AW-1:0] LAST_ROUND = RK_AW'(ROUND_COUNT - 1);

    logic [2:0]        r_state, n_state;
    logic [RK_AW-1:0]  r_cnt, n_cnt;
    logic              r_keys_ready, n_keys_ready;
    logic [63:0]       r_key_high;
    logic [63:0]       r_key_low;
    logic              r_decrypt;
    logic [127:0]      r_blk;
    logic [31:0]       r_x [4];
    logic [31:0]       n_x [4];
    logic              r_out_valid, n_out_valid;
    logic [127:0]      r_out_data, n_out_data;

    logic [31:0]       r_rk_mem [ROUND_COUNT];
    logic [31:0]       r_rk;
    logic              rk_we;
    logic [RK_AW-1:0]  rk_raddr;
    logic [RK_AW-1:0]  rd_round;

    logic              in_beat;
    logic              cfg_beat;
    logic [31:0]       round_key;
    logic [31:0]       nx;

    assign o_cfg_ready   = 1'b1;
    assign cfg_beat      = i_cfg_valid;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    // Round-key RAM: one write port for the schedule, one registered read port
    assign rk_we    = (r_state == ST_EXPAND);
    assign rd_round = (r_state == ST_LOAD) ? '0 : r_cnt + 1'b1;
    assign rk_raddr = r_decrypt ? ~rd_round : rd_round;

    always_ff @(posedge i_clk) begin
        if (rk_we) begin
            r_rk_mem[r_cnt] <= nx;
        end
        r_rk <= r_rk_mem[rk_raddr];
    end

    // Shared round datapath
    assign round_key = (r_state == ST_EXPAND) ? ck_word(r_cnt) : r_rk;

    sm4_round u_round (
        .i_x0      (r_x[0]),
        .i_x1      (r_x[1]),
        .i_x2      (r_x[2]),
        .i_x3      (r_x[3]),
        .i_rk      (round_key),
        .i_key_mix (r_state == ST_EXPAND),
        .o_nx      (nx)
    );

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
            r_decrypt  <= 1'b0;
        end else if (cfg_beat) begin
            case (i_cfg_index)
                CFG_KEY_HIGH: r_key_high <= i_cfg_data;
                CFG_KEY_LOW:  r_key_low  <= i_cfg_data;
                CFG_DECRYPT:  r_decrypt  <= i_cfg_data[0];
                default:      ;
            endcase
        end
    end

    // Sequencer next state
    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_keys_ready = r_keys_ready;
        n_x          = r_x;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;

        if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (in_beat) begin
                    n_cnt = '0;
                    if (r_keys_ready) begin
                        n_state = ST_LOAD;
                    end else begin
                        n_state = ST_EXPAND;
                        n_x[0]  = r_key_high[63:32] ^ FK0;
                        n_x[1]  = r_key_high[31:0]  ^ FK1;
                        n_x[2]  = r_key_low[63:32]  ^ FK2;
                        n_x[3]  = r_key_low[31:0]   ^ FK3;
                    end
                end
            end
            ST_EXPAND: begin
                n_x[0] = r_x[1];
                n_x[1] = r_x[2];
                n_x[2] = r_x[3];
                n_x[3] = nx;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == LAST_ROUND) begin
                    n_keys_ready = 1'b1;
                    n_state      = ST_LOAD;
                end
            end
            ST_LOAD: begin
                // first round key is being read this cycle
                n_x[0]  = r_blk[63:32];
                n_x[1]  = r_blk[31:0];
                n_x[2]  = r_blk[127:96];
                n_x[3]  = r_blk[95:64];
                n_cnt   = '0;
                n_state = ST_CRYPT;
            end
            ST_CRYPT: begin
                n_x[0] = r_x[1];
                n_x[1] = r_x[2];
                n_x[2] = r_x[3];
                n_x[3] = nx;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == LAST_ROUND) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                // final word reversal into the output register
                if (!r_out_valid || m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {r_x[1], r_x[0], r_x[3], r_x[2]};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // a key write stales the schedule
        if (cfg_beat && (i_cfg_index == CFG_KEY_HIGH || i_cfg_index == CFG_KEY_LOW)) begin
            n_keys_ready = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_keys_ready <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_keys_ready <= n_keys_ready;
            r_out_valid  <= n_out_valid;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_cnt      <= n_cnt;
        r_x        <= n_x;
        r_out_data <= n_out_data;
        if (in_beat) begin
            r_blk <= s_axis_tdata;
        end
    end

    // A block accepted with a stale schedule runs the key expansion first
    a_expand_on_stale: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_beat && !r_keys_ready) |=> (r_state == ST_EXPAND))
        else $error("stale schedule did not start key expansion");

    // Data rounds never start on a stale schedule
    a_load_keys_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOAD) |-> r_keys_ready)
        else $error("data rounds started with stale round keys");

    // Exactly ROUND_COUNT data rounds before the result stage
    a_last_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CRYPT && r_cnt == LAST_ROUND) |=> (r_state == ST_DONE))
        else $error("round count did not end the data rounds");

    // No result is overwritten while still waiting to be taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !m_axis_tready) |=> (r_out_valid && $stable(r_out_data)))
        else $error("pending result was overwritten");

endmodule

>>> tb/sm4_block_cipher_unit_checker.sv
// Checker for the SM4 cipher unit: watches all channels, predicts every result beat and compares.
`timescale 1ns / 1ps

module sm4_block_cipher_unit_checker import sm4_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // configuration write channel
    input  logic         i_cfg_valid,
    input  logic         i_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [63:0]  i_cfg_data,
    // input blocks
    input  logic         i_blk_valid,
    input  logic         i_blk_ready,
    input  logic [127:0] i_blk_data,   // [63:0] block_high, [127:64] block_low
    // result blocks
    input  logic         i_res_valid,
    input  logic         i_res_ready,
    input  logic [127:0] i_res_data,   // [63:0] result_high, [127:64] result_low
    // status toward the testbench top
    output int           o_mismatches,
    output int           o_outstanding,
    output int           o_checked,
    output int           o_decrypted,
    output int           o_schedules,
    output int           o_reg_writes
);

    // One expected result beat, packed like m_axis_tdata
    typedef struct packed {
        logic [63:0] res_low;
        logic [63:0] res_high;
    } t_cipher_out;

    // Substitution table of the cipher
    localparam logic [7:0] SUB_TABLE [256] = '{
        8'hd6, 8'h90, 8'he9, 8'hfe, 8'hcc, 8'he1, 8'h3d, 8'hb7,
        8'h16, 8'hb6, 8'h14, 8'hc2, 8'h28, 8'hfb, 8'h2c, 8'h05,
        8'h2b, 8'h67, 8'h9a, 8'h76, 8'h2a, 8'hbe, 8'h04, 8'hc3,
        8'haa, 8'h44, 8'h13, 8'h26, 8'h49, 8'h86, 8'h06, 8'h99,
        8'h9c, 8'h42, 8'h50, 8'hf4, 8'h91, 8'hef, 8'h98, 8'h7a,
        8'h33, 8'h54, 8'h0b, 8'h43, 8'hed, 8'hcf, 8'hac, 8'h62,
        8'he4, 8'hb3, 8'h1c, 8'ha9, 8'hc9, 8'h08, 8'he8, 8'h95,
        8'h80, 8'hdf, 8'h94, 8'hfa, 8'h75, 8'h8f, 8'h3f, 8'ha6,
        8'h47, 8'h07, 8'ha7, 8'hfc, 8'hf3, 8'h73, 8'h17, 8'hba,
        8'h83, 8'h59, 8'h3c, 8'h19, 8'he6, 8'h85, 8'h4f, 8'ha8,
        8'h68, 8'h6b, 8'h81, 8'hb2, 8'h71, 8'h64, 8'hda, 8'h8b,
        8'hf8, 8'heb, 8'h0f, 8'h4b, 8'h70, 8'h56, 8'h9d, 8'h35,
        8'h1e, 8'h24, 8'h0e, 8'h5e, 8'h63, 8'h58, 8'hd1, 8'ha2,
        8'h25, 8'h22, 8'h7c, 8'h3b, 8'h01, 8'h21, 8'h78, 8'h87,
        8'hd4, 8'h00, 8'h46, 8'h57, 8'h9f, 8'hd3, 8'h27, 8'h52,
        8'h4c, 8'h36, 8'h02, 8'he7, 8'ha0, 8'hc4, 8'hc8, 8'h9e,
        8'hea, 8'hbf, 8'h8a, 8'hd2, 8'h40, 8'hc7, 8'h38, 8'hb5,
        8'ha3, 8'hf7, 8'hf2, 8'hce, 8'hf9, 8'h61, 8'h15, 8'ha1,
        8'he0, 8'hae, 8'h5d, 8'ha4, 8'h9b, 8'h34, 8'h1a, 8'h55,
        8'had, 8'h93, 8'h32, 8'h30, 8'hf5, 8'h8c, 8'hb1, 8'he3,
        8'h1d, 8'hf6, 8'he2, 8'h2e, 8'h82, 8'h66, 8'hca, 8'h60,
        8'hc0, 8'h29, 8'h23, 8'hab, 8'h0d, 8'h53, 8'h4e, 8'h6f,
        8'hd5, 8'hdb, 8'h37, 8'h45, 8'hde, 8'hfd, 8'h8e, 8'h2f,
        8'h03, 8'hff, 8'h6a, 8'h72, 8'h6d, 8'h6c, 8'h5b, 8'h51,
        8'h8d, 8'h1b, 8'haf, 8'h92, 8'hbb, 8'hdd, 8'hbc, 8'h7f,
        8'h11, 8'hd9, 8'h5c, 8'h41, 8'h1f, 8'h10, 8'h5a, 8'hd8,
        8'h0a, 8'hc1, 8'h31, 8'h88, 8'ha5, 8'hcd, 8'h7b, 8'hbd,
        8'h2d, 8'h74, 8'hd0, 8'h12, 8'hb8, 8'he5, 8'hb4, 8'hb0,
        8'h89, 8'h69, 8'h97, 8'h4a, 8'h0c, 8'h96, 8'h77, 8'h7e,
        8'h65, 8'hb9, 8'hf1, 8'h09, 8'hc5, 8'h6e, 8'hc6, 8'h84,
        8'h18, 8'hf0, 8'h7d, 8'hec, 8'h3a, 8'hdc, 8'h4d, 8'h20,
        8'h79, 8'hee, 8'h5f, 8'h3e, 8'hd7, 8'hcb, 8'h39, 8'h48
    };

    // Key schedule system parameters
    localparam logic [31:0] SYS_FK [4] = '{32'hA3B1BAC6, 32'h56AA3350,
                                           32'h677D9197, 32'hB27022DC};

    // Shadow of the register file and the round-key store
    logic [63:0]  cipher_key_high;
    logic [63:0]  cipher_key_low;
    logic         decrypt_on;
    logic         schedule_fresh;
    logic [31:0]  round_keys [ROUND_COUNT];
    t_cipher_out  expected_blocks [$];

    int mismatch_count;
    int checked_count;
    int decrypt_count;
    int schedule_count;
    int write_count;

    function automatic logic [31:0] rol32(input logic [31:0] v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    function automatic logic [31:0] sub_word(input logic [31:0] v);
        return {SUB_TABLE[v[31:24]], SUB_TABLE[v[23:16]],
                SUB_TABLE[v[15:8]], SUB_TABLE[v[7:0]]};
    endfunction

    // byte b of CK[idx], most significant first, is (4*idx+b)*7 mod 256
    function automatic logic [31:0] ck_const(input int unsigned idx);
        logic [31:0] w;
        w = '0;
        for (int b = 0; b < 4; b++) w = {w[23:0], 8'((4 * idx + b) * 7)};
        return w;
    endfunction

    // Rebuild all 32 round keys from the current cipher key
    task automatic expand_schedule();
        logic [31:0] k [4];
        logic [31:0] t;
        logic [31:0] nk;
        k[0] = cipher_key_high[63:32] ^ SYS_FK[0];
        k[1] = cipher_key_high[31:0]  ^ SYS_FK[1];
        k[2] = cipher_key_low[63:32]  ^ SYS_FK[2];
        k[3] = cipher_key_low[31:0]   ^ SYS_FK[3];
        for (int i = 0; i < ROUND_COUNT; i++) begin
            t  = sub_word(k[1] ^ k[2] ^ k[3] ^ ck_const(i));
            nk = k[0] ^ t ^ rol32(t, 13) ^ rol32(t, 23);
            k[0] = k[1];
            k[1] = k[2];
            k[2] = k[3];
            k[3] = nk;
            round_keys[i] = nk;
        end
    endtask

    // 32 rounds, then the final word reversal
    function automatic t_cipher_out encipher(input logic [127:0] blk);
        logic [31:0] x [4];
        logic [31:0] rk;
        logic [31:0] t;
        logic [31:0] nx;
        t_cipher_out r;
        x[0] = blk[63:32];
        x[1] = blk[31:0];
        x[2] = blk[127:96];
        x[3] = blk[95:64];
        for (int i = 0; i < ROUND_COUNT; i++) begin
            rk = decrypt_on ? round_keys[ROUND_COUNT - 1 - i] : round_keys[i];
            t  = sub_word(x[1] ^ x[2] ^ x[3] ^ rk);
            nx = x[0] ^ t ^ rol32(t, 2) ^ rol32(t, 10) ^ rol32(t, 18) ^ rol32(t, 24);
            x[0] = x[1];
            x[1] = x[2];
            x[2] = x[3];
            x[3] = nx;
        end
        r.res_high = {x[3], x[2]};
        r.res_low  = {x[1], x[0]};
        return r;
    endfunction

    // Beat monitor: result side first so a block never meets its own result
    always @(posedge i_clk) begin
        t_cipher_out want;
        if (!i_rst_n) begin
            cipher_key_high = '0;
            cipher_key_low  = '0;
            decrypt_on      = 1'b0;
            schedule_fresh  = 1'b0;
            expected_blocks.delete();
            mismatch_count  = 0;
            checked_count   = 0;
            decrypt_count   = 0;
            schedule_count  = 0;
            write_count     = 0;
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (expected_blocks.size() == 0) begin
                    $error("result beat with no block pending: %h", i_res_data);
                    mismatch_count++;
                end else begin
                    want = expected_blocks.pop_front();
                    checked_count++;
                    if (i_res_data[63:0] !== want.res_high) begin
                        $error("result_high: expected %h, actual %h",
                               want.res_high, i_res_data[63:0]);
                        mismatch_count++;
                    end
                    if (i_res_data[127:64] !== want.res_low) begin
                        $error("result_low: expected %h, actual %h",
                               want.res_low, i_res_data[127:64]);
                        mismatch_count++;
                    end
                end
            end

            // register writes; a key write stales the schedule, the spare index is dropped
            if (i_cfg_valid && i_cfg_ready) begin
                write_count++;
                case (i_cfg_index)
                    CFG_KEY_HIGH: begin
                        cipher_key_high = i_cfg_data;
                        schedule_fresh  = 1'b0;
                    end
                    CFG_KEY_LOW: begin
                        cipher_key_low = i_cfg_data;
                        schedule_fresh = 1'b0;
                    end
                    CFG_DECRYPT: begin
                        decrypt_on = i_cfg_data[0];
                    end
                    default: ;
                endcase
            end

            if (i_blk_valid && i_blk_ready) begin
                if (!schedule_fresh) begin
                    expand_schedule();
                    schedule_fresh = 1'b1;
                    schedule_count++;
                end
                if (decrypt_on) decrypt_count++;
                expected_blocks.push_back(encipher(i_blk_data));
            end
        end
        o_mismatches  <= mismatch_count;
        o_outstanding <= expected_blocks.size();
        o_checked     <= checked_count;
        o_decrypted   <= decrypt_count;
        o_schedules   <= schedule_count;
        o_reg_writes  <= write_count;
    end

endmodule

>>> tb/sm4_block_cipher_unit_tb.sv
// Testbench top for the SM4 cipher unit: clock, reset, block and register stimulus, verdict.
`timescale 1ns / 1ps

module sm4_block_cipher_unit_tb;
    import sm4_pkg::*;

    localparam int          NUM_PHASES  = 8;
    localparam int          PHASE_ITEMS = 200;
    localparam int          HOLD_CYCLES = 300;
    localparam int          CYCLE_LIMIT = 700000;
    localparam int          END_SETTLE  = 80;
    localparam logic [1:0]  CFG_SPARE   = 2'd3;   // no register behind this index

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         i_cfg_valid   = 1'b0;
    logic [1:0]   i_cfg_index   = CFG_KEY_HIGH;
    logic [63:0]  i_cfg_data    = '0;
    logic         s_axis_tvalid = 1'b0;
    logic [127:0] s_axis_tdata  = '0;
    logic         m_axis_tready = 1'b0;
    logic         o_cfg_ready;
    logic         s_axis_tready;
    logic         m_axis_tvalid;
    logic [127:0] m_axis_tdata;

    int mismatches;
    int outstanding;
    int checked;
    int decrypted;
    int schedules;
    int reg_writes;
    int cycle_count = 0;

    bit idle_on  = 1'b1;
    bit hold_req = 1'b0;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    sm4_block_cipher_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sm4_block_cipher_unit_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_blk_valid   (s_axis_tvalid),
        .i_blk_ready   (s_axis_tready),
        .i_blk_data    (s_axis_tdata),
        .i_res_valid   (m_axis_tvalid),
        .i_res_ready   (m_axis_tready),
        .i_res_data    (m_axis_tdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding),
        .o_checked     (checked),
        .o_decrypted   (decrypted),
        .o_schedules   (schedules),
        .o_reg_writes  (reg_writes)
    );

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count, outstanding);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random stall bursts, one long hold-off on request
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (idle_on && ($urandom_range(0, 5) == 0)) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    function automatic logic [63:0] random_word64();
        return {$urandom, $urandom};
    endfunction

    // Block halves: mostly random, now and then an extreme
    function automatic logic [63:0] random_half();
        case ($urandom_range(0, 19))
            0:       return '0;
            1:       return '1;
            default: return random_word64();
        endcase
    endfunction

    // Offer one block and hold it until it is taken; valid stays up for the next one
    task automatic send_block(input logic [63:0] blk_high, input logic [63:0] blk_low);
        if (idle_on && ($urandom_range(0, 4) == 0)) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {blk_low, blk_high};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
    endtask

    // Drop valid and wait until every block has come back
    task automatic drain(input int settle);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    // One register beat; valid is left high so back-to-back writes need no toggle
    task automatic write_reg(input logic [1:0] idx, input logic [63:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do begin
            @(posedge i_clk);
        end while (!o_cfg_ready);
    endtask

    task automatic cfg_release();
        i_cfg_valid <= 1'b0;
    endtask

    // New settings for a random phase
    task automatic reconfigure();
        case ($urandom_range(0, 5))
            0: begin
                write_reg(CFG_KEY_HIGH, random_word64());
                write_reg(CFG_KEY_LOW, random_word64());
            end
            1: write_reg(CFG_KEY_HIGH, random_word64());
            2: write_reg(CFG_KEY_LOW, random_word64());
            3: begin
                write_reg(CFG_KEY_HIGH, $urandom_range(0, 1) ? '1 : '0);
                write_reg(CFG_KEY_LOW, $urandom_range(0, 1) ? '1 : '0);
            end
            default: ;
        endcase
        // only bit 0 picks the direction, the rest of the word must be dropped
        write_reg(CFG_DECRYPT, random_word64());
        if ($urandom_range(0, 2) == 0) write_reg(CFG_SPARE, random_word64());
        cfg_release();
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: all-zero key, encrypt, schedule built on the first block
        send_block('0, '0);
        send_block('1, '1);
        send_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
        send_block(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001);
        drain(4);

        // Standard known-answer key and block
        write_reg(CFG_KEY_HIGH, 64'h0123_4567_89AB_CDEF);
        write_reg(CFG_KEY_LOW, 64'hFEDC_BA98_7654_3210);
        cfg_release();
        send_block(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        send_block(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        drain(4);

        // Direction change alone keeps the schedule
        write_reg(CFG_DECRYPT, 64'd1);
        cfg_release();
        send_block(64'h681E_DF34_D206_965E, 64'h86B3_E94F_536E_4246);
        drain(4);

        // Write to the spare index changes nothing
        write_reg(CFG_SPARE, 64'hDEAD_BEEF_0BAD_F00D);
        cfg_release();
        send_block(64'h681E_DF34_D206_965E, 64'h86B3_E94F_536E_4246);
        drain(4);

        // Wide value on the direction register: bit 0 clear means encrypt
        write_reg(CFG_DECRYPT, 64'hFFFF_FFFF_FFFF_FFFE);
        cfg_release();
        send_block('0, '1);
        drain(4);

        // Key halves rewritten one at a time
        write_reg(CFG_KEY_HIGH, '1);
        cfg_release();
        send_block('1, '1);
        send_block('0, '0);
        drain(4);
        write_reg(CFG_KEY_LOW, '1);
        write_reg(CFG_DECRYPT, '1);
        cfg_release();
        send_block('0, '0);
        send_block('1, '1);
        drain(4);
        write_reg(CFG_KEY_HIGH, '0);
        write_reg(CFG_KEY_LOW, '0);
        cfg_release();
        send_block(64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210);
        send_block('1, '0);
        drain(4);

        // Random phases; the last one runs without idling
        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            idle_on = (ph < NUM_PHASES - 1);
            reconfigure();
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (ph == 1 && n == 60) hold_req <= 1'b1;
                send_block(random_half(), random_half());
            end
            drain(ph == NUM_PHASES - 1 ? END_SETTLE : 4);
        end

        $display("Checked %0d result beats (%0d decrypted) over %0d key schedules, %0d reg writes.",
                 checked, decrypted, schedules, reg_writes);
        $display("Random phases with stalls on both sides and one %0d-cycle receiver hold-off.",
                 HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

>>> sim.f
src/sm4_pkg.sv
src/sm4_round.sv
src/sm4_block_cipher_unit.sv
tb/sm4_block_cipher_unit_checker.sv
tb/sm4_block_cipher_unit_tb.sv
